// ----- hdl/tqes_pkg.sv -----
// Shared types and constants for the terminal query escape stripper.
// No dependencies; compiled first.
`default_nettype none

package tqes_pkg;

  localparam logic [7:0] ESC_CODE = 8'h1B;
  localparam logic [7:0] CH_Z     = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7E;
  localparam logic [7:0] CH_C     = 8'h63;  // 'c'
  localparam logic [7:0] CH_N     = 8'h6E;  // 'n'

  // One result item as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_message;
  } out_item_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCAN_IN,   // scan the byte on the input channel, store it in the ring
    OP_READ,      // fetch the next unscanned byte from the ring
    OP_SCAN_MEM,  // scan the fetched byte
    OP_FLUSH,     // end of message: emit the pending ESC and rescan behind it
    OP_FINISH     // close the message: release the held result with end mark
  } tqes_op_t;

  typedef struct packed {
    tqes_op_t op;
  } tqes_cmd_t;

  typedef struct packed {
    logic space;       // result queue can take one more item
    logic miss;        // scanned byte breaks the pending sequence
    logic rest_empty;  // no unscanned bytes left in the ring
    logic pend_nz;     // a sequence is pending
    logic last;        // last byte taken closes the message
  } tqes_status_t;

endpackage

`default_nettype wire

// ----- hdl/tqes_ifs.sv -----
// Valid/ready channel interfaces for the input bytes and the result items.
// Standalone; no package needed.
`default_nettype none

interface tqes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface tqes_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, out_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, out_byte, byte_valid, end_of_message, output ready);
endinterface

`default_nettype wire

// ----- hdl/tqes_out_fifo.sv -----
// Two-entry result queue that decouples the scanner from the receiver.
// Uses tqes_pkg and tqes_out_if.
`default_nettype none

module tqes_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire tqes_pkg::out_item_t push_item,
  output logic                     space,
  tqes_out_if.source               out_ch
);
  import tqes_pkg::*;

  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_FULL = 2'd2;

  logic [1:0] cnt_r, cnt_nxt;
  out_item_t  item0_r, item1_r;
  logic       pop;

  assign pop   = (cnt_r != 2'd0) && out_ch.ready;
  assign space = (cnt_r != CNT_FULL);

  assign out_ch.valid          = (cnt_r != 2'd0);
  assign out_ch.out_byte       = item0_r.out_byte;
  assign out_ch.byte_valid     = item0_r.byte_valid;
  assign out_ch.end_of_message = item0_r.end_of_message;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == CNT_FULL) begin
        item0_r <= item1_r;
      end else if (push) begin
        item0_r <= push_item;
      end
    end else if (push) begin
      if (cnt_r == CNT_ONE) begin
        item1_r <= push_item;
      end else begin
        item0_r <= push_item;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tqes_ctrl.sv -----
// Sequencer for the stripper: accepts bytes, walks rescans and closes messages.
// Uses tqes_pkg command and status types.
`default_nettype none

module tqes_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_last,
  input  wire tqes_pkg::tqes_status_t st,
  output tqes_pkg::tqes_cmd_t         cmd,
  output logic                        in_ready
);
  import tqes_pkg::*;

  typedef enum logic [2:0] {
    S_ACCEPT,
    S_READ,
    S_EVAL,
    S_FLUSH,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_ACCEPT: begin
        in_ready = st.space;
        if (in_valid && st.space) begin
          cmd.op = OP_SCAN_IN;
          if (st.miss || in_last) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (st.rest_empty) begin
          priority if (st.last && st.pend_nz) begin
            state_nxt = S_FLUSH;
          end else if (st.last) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_ACCEPT;
          end
        end else begin
          cmd.op    = OP_READ;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.space) begin
          cmd.op    = OP_SCAN_MEM;
          state_nxt = S_READ;
        end
      end
      S_FLUSH: begin
        if (st.space) begin
          cmd.op    = OP_FLUSH;
          state_nxt = S_READ;
        end
      end
      S_FINISH: begin
        if (st.space) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_ACCEPT;
        end
      end
      default: begin
        state_nxt = S_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACCEPT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tqes_dp.sv -----
// Datapath: byte ring with pending/unscanned windows, scanner and result hold.
// Uses tqes_pkg; driven by tqes_ctrl commands.
`default_nettype none

module tqes_dp #(
  parameter int MAX_SEQ = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tqes_pkg::tqes_cmd_t  cmd,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_last,
  input  wire logic                 fifo_space,
  output tqes_pkg::tqes_status_t    st,
  output logic                      push,
  output tqes_pkg::out_item_t       push_item
);
  import tqes_pkg::*;

  // Ring holds pending bytes followed by bytes still to be scanned.
  localparam int AW    = $clog2(MAX_SEQ + 2);
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(MAX_SEQ + 1);

  typedef enum logic [1:0] {
    ACT_EMIT,
    ACT_PEND,
    ACT_DROP,
    ACT_MISS
  } act_t;

  logic [7:0]    ring [DEPTH];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] s_r, s_nxt;      // start of pending sequence
  logic [CW-1:0] pc_r, pc_nxt;    // pending count
  logic [AW-1:0] e_r, e_nxt;      // end of stored bytes
  logic          last_r;
  logic [7:0]    hold_byte_r;
  logic          hold_vld_r;

  logic [AW-1:0] scan_addr;
  logic [7:0]    cur;
  logic          is_final;
  logic          scanning;
  logic          step_last;
  logic          emit;
  logic [7:0]    emit_byte;
  act_t          act;

  assign scan_addr = s_r + AW'(pc_r);
  assign scanning  = (cmd.op == OP_SCAN_IN) || (cmd.op == OP_SCAN_MEM);
  assign cur       = (cmd.op == OP_SCAN_IN) ? in_byte : rd_data_r;
  assign is_final  = (cur >= FINAL_LO) && (cur <= FINAL_HI);
  assign step_last = (cmd.op == OP_SCAN_IN) ? in_last : last_r;

  always_comb begin
    priority if (pc_r == CW'(0)) begin
      act = (cur == ESC_CODE) ? ACT_PEND : ACT_EMIT;
    end else if (pc_r == CW'(1)) begin
      if (cur == CH_Z) begin
        act = ACT_DROP;
      end else if (cur == CH_LBRK) begin
        act = ACT_PEND;
      end else begin
        act = ACT_MISS;
      end
    end else if (is_final) begin
      act = ((cur == CH_C) || (cur == CH_N)) ? ACT_DROP : ACT_MISS;
    end else if (pc_r >= CW'(MAX_SEQ)) begin
      act = ACT_MISS;  // overlong parameter run
    end else begin
      act = ACT_PEND;
    end
  end

  always_comb begin
    s_nxt     = s_r;
    pc_nxt    = pc_r;
    e_nxt     = (cmd.op == OP_SCAN_IN) ? scan_addr + AW'(1) : e_r;
    emit      = 1'b0;
    emit_byte = ESC_CODE;
    if (scanning) begin
      unique case (act)
        ACT_EMIT: begin
          s_nxt     = s_r + AW'(1);
          emit      = 1'b1;
          emit_byte = cur;
        end
        ACT_PEND: begin
          pc_nxt = pc_r + CW'(1);
        end
        ACT_DROP: begin
          s_nxt  = scan_addr + AW'(1);
          pc_nxt = '0;
        end
        ACT_MISS: begin
          // emit the ESC, rescan everything behind it
          s_nxt  = s_r + AW'(1);
          pc_nxt = '0;
          emit   = 1'b1;
        end
        default: begin
          s_nxt = s_r;
        end
      endcase
    end else if (cmd.op == OP_FLUSH) begin
      s_nxt  = s_r + AW'(1);
      pc_nxt = '0;
      emit   = 1'b1;
    end
  end

  // Within a closing item, keep the newest result back so it can carry the end mark.
  always_comb begin
    push      = 1'b0;
    push_item = '{out_byte: hold_byte_r, byte_valid: 1'b1, end_of_message: 1'b0};
    if (cmd.op == OP_FINISH) begin
      push      = 1'b1;
      push_item = '{out_byte:       hold_vld_r ? hold_byte_r : 8'h00,
                    byte_valid:     hold_vld_r,
                    end_of_message: 1'b1};
    end else if (emit) begin
      if (step_last) begin
        push = hold_vld_r;
      end else begin
        push      = 1'b1;
        push_item = '{out_byte: emit_byte, byte_valid: 1'b1, end_of_message: 1'b0};
      end
    end
  end

  always_comb begin
    st.space      = fifo_space;
    st.miss       = (act == ACT_MISS);
    st.rest_empty = (scan_addr == e_r);
    st.pend_nz    = (pc_r != CW'(0));
    st.last       = last_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SCAN_IN) begin
      ring[scan_addr] <= in_byte;
    end
    if (cmd.op == OP_READ) begin
      rd_data_r <= ring[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r        <= '0;
      pc_r       <= '0;
      e_r        <= '0;
      last_r     <= 1'b0;
      hold_vld_r <= 1'b0;
    end else begin
      s_r  <= s_nxt;
      pc_r <= pc_nxt;
      e_r  <= e_nxt;
      if (cmd.op == OP_SCAN_IN) begin
        last_r <= in_last;
      end
      if (cmd.op == OP_FINISH) begin
        hold_vld_r <= 1'b0;
      end else if (emit && step_last) begin
        hold_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit && step_last && (cmd.op != OP_FINISH)) begin
      hold_byte_r <= emit_byte;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/terminal_query_escape_stripper_top.sv -----
// Terminal query escape stripper: drops ESC Z and CSI ... 'c' / 'n' from a
// byte stream and passes every other byte through in order.
//
// Channels: in_ch carries in_byte and in_last (final byte of a message);
// out_ch carries out_byte, byte_valid and end_of_message. A transfer takes
// place when valid and ready are both high at a rising clock edge.
// A passed byte is registered in the result queue before it reaches out_ch.
// A byte that needs no rescan is scanned as it is taken. A byte that breaks a
// pending sequence emits the ESC, then every byte behind it is rescanned
// (ring read, then evaluate), and a final empty-ring check ends the rescan.
// A message-closing byte also takes that check plus a close step; each pending
// ESC flushed at the end adds a flush step, then the rescan and check again.
// A message with no output closes with one item: byte_valid 0, out_byte 0.
// Results pass through a two-entry queue, so bytes are still taken while
// one result waits; when the receiver stalls and the queue fills, in_ready
// drops and the scanner holds its place.
// Reset (rst_n low, synchronous) empties the pending sequence and the queue;
// the byte ring needs no clearing.
// MAX_SEQ sets the longest pending sequence; the ring holds
// 2**clog2(MAX_SEQ+2) bytes.
`default_nettype none

module terminal_query_escape_stripper_top #(
  parameter int MAX_SEQ = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tqes_in_if.sink    in_ch,
  tqes_out_if.source out_ch
);
  import tqes_pkg::*;

  tqes_cmd_t    cmd;
  tqes_status_t st;
  logic         fifo_space;
  logic         push;
  out_item_t    push_item;

  tqes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.in_last),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ch.ready)
  );

  tqes_dp #(
    .MAX_SEQ (MAX_SEQ)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_byte    (in_ch.in_byte),
    .in_last    (in_ch.in_last),
    .fifo_space (fifo_space),
    .st         (st),
    .push       (push),
    .push_item  (push_item)
  );

  tqes_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .space     (fifo_space),
    .out_ch    (out_ch)
  );

  // A closing byte always sends the sequencer through its close-out steps.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.in_last |=> !in_ch.ready)
    else $error("input taken right after a message-closing byte");

  // A result without data is only ever the end marker.
  a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.byte_valid |-> out_ch.end_of_message &&
    (out_ch.out_byte == 8'h00))
    else $error("bare result without end mark or with nonzero byte");

  // After plain text is taken with nothing pending, the output is valid the next cycle.
  a_plain_passes: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && !in_ch.in_last && !st.pend_nz &&
    (in_ch.in_byte != ESC_CODE) |=> out_ch.valid)
    else $error("plain byte did not reach the output");

endmodule

`default_nettype wire
